>>> design/velocity_pid_bangbang_controller_macros.svh
// ----------------------------------------------------------------------------
// Velocity PID / bang-bang controller assertion macros
// Shared clocked assertion forms, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_PID_BANGBANG_CONTROLLER_MACROS_SVH
`define VELOCITY_PID_BANGBANG_CONTROLLER_MACROS_SVH

// check a property on every rising clock edge outside reset
`define VPBB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds on a rising clock edge outside reset
`define VPBB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> design/vpbb_pkg.sv
// ----------------------------------------------------------------------------
// Velocity PID / bang-bang controller package
// Register indexes, reset values and fixed drive constants.
// ----------------------------------------------------------------------------
`default_nettype none

package vpbb_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_VELOCITY = 3'd0,
    REG_CONTROL_MODE    = 3'd1,
    REG_GAIN_P          = 3'd2,
    REG_GAIN_I          = 3'd3,
    REG_GAIN_D          = 3'd4,
    REG_GAIN_FF         = 3'd5,
    REG_INTEGRAL_WINDOW = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    MODE_PID       = 1'b0,
    MODE_BANG_BANG = 1'b1
  } ctrl_mode_e;

  localparam logic [15:0] GainPReset    = 16'd41;
  localparam logic [15:0] GainIReset    = 16'd205;
  localparam logic [15:0] GainDReset    = 16'd0;
  localparam logic [15:0] GainFfReset   = 16'd492;
  localparam logic [15:0] WindowReset   = 16'd12800;

  localparam logic signed [15:0] DriveMax  = 16'sh7fff;
  localparam logic signed [15:0] DriveMin  = -16'sh8000;
  localparam logic signed [15:0] BangFull  = 16'sd25600;

  localparam logic signed [31:0] IntegMax  = 32'sh7fff_ffff;
  localparam logic signed [31:0] IntegMin  = 32'sh8000_0000;

endpackage

`default_nettype wire

>>> design/velocity_pid_bangbang_controller.sv
// ----------------------------------------------------------------------------
// Velocity PID / bang-bang controller
// Turns one measured velocity word into one drive word per tick, with a
// saturating windowed integral, feedforward on target and a bang-bang mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: measured_velocity_i with in_valid_i / in_ready_o.
//   Output channel: drive_level_o, coast_stop_o, drive_saturated_o with
//   out_valid_o / out_ready_i. Configuration: cfg_we_i writes cfg_data_i
//   to register cfg_index_i; write only while the block is idle.
//   Pipeline: input register, error and integral update, four multiplies,
//   then sum, rounding and clamp into the output register.
//   Throughput: one word per cycle unless stalled; the error stage state is
//   registered, so back-to-back words see each other's state.
//   Reset: registers take their reset values, integral and previous error
//   clear, the pipeline empties.
//   Receiver stall: the whole pipeline holds while the output register is
//   full and out_ready_i is low; in_ready_o drops in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "velocity_pid_bangbang_controller_macros.svh"

module velocity_pid_bangbang_controller
  import vpbb_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [15:0]               cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [15:0]        measured_velocity_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [15:0]             drive_level_o,
  output logic                           coast_stop_o,
  output logic                           drive_saturated_o
);

  logic signed [15:0] target_q;
  ctrl_mode_e         mode_q;
  logic [15:0]        gain_p_q, gain_i_q, gain_d_q, gain_ff_q, window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      mode_q   <= MODE_PID;
      gain_p_q <= GainPReset;
      gain_i_q <= GainIReset;
      gain_d_q <= GainDReset;
      gain_ff_q <= GainFfReset;
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TARGET_VELOCITY: target_q <= cfg_data_i;
        REG_CONTROL_MODE:    mode_q <= ctrl_mode_e'(cfg_data_i[0]);
        REG_GAIN_P:          gain_p_q <= cfg_data_i;
        REG_GAIN_I:          gain_i_q <= cfg_data_i;
        REG_GAIN_D:          gain_d_q <= cfg_data_i;
        REG_GAIN_FF:         gain_ff_q <= cfg_data_i;
        REG_INTEGRAL_WINDOW: window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1_q, v2_q, v3_q, out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // input register
  logic signed [15:0] meas_q;

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      meas_q <= measured_velocity_i;
    end
  end

  // error, integral and derivative
  logic signed [31:0] integ_q, integ_d;
  logic signed [16:0] prev_err_q;
  logic signed [16:0] err;
  logic [16:0]        err_mag;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_acc;
  logic               integ_on, in_window, sign_flip;
  logic signed [17:0] deriv;

  always_comb begin
    err       = 17'(target_q) - 17'(meas_q);
    err_mag   = err[16] ? 17'(-err) : 17'(err);
    integ_on  = (gain_i_q != '0);
    in_window = err_mag < {1'b0, window_q};
    integ_sum = 33'(integ_q) + 33'(err);
    if (integ_sum[32] != integ_sum[31]) begin
      integ_acc = integ_sum[32] ? IntegMin : IntegMax;
    end else begin
      integ_acc = integ_sum[31:0];
    end
    sign_flip = ((!err[16] && err != '0) && prev_err_q[16]) ||
                (err[16] && (!prev_err_q[16] && prev_err_q != '0));
    integ_d = integ_q;
    if (integ_on && in_window) begin
      integ_d = integ_acc;
    end
    if (integ_on && sign_flip) begin
      integ_d = '0;
    end
    deriv = 18'(err) - 18'(prev_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
    end else if (adv && v1_q) begin
      integ_q    <= integ_d;
      prev_err_q <= err;
    end
  end

  logic signed [16:0] err2_q;
  logic signed [31:0] integ2_q;
  logic signed [17:0] deriv2_q;
  logic               below2_q, coast2_q;

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      err2_q   <= err;
      integ2_q <= integ_d;
      deriv2_q <= deriv;
      below2_q <= !err[16] && (err != '0);
      coast2_q <= (target_q == '0);
    end
  end

  // products
  logic signed [33:0] prod_p_q;
  logic signed [48:0] prod_i_q;
  logic signed [34:0] prod_d_q;
  logic signed [32:0] prod_ff_q;
  logic               below3_q, coast3_q;

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      prod_p_q  <= err2_q * $signed({1'b0, gain_p_q});
      prod_i_q  <= integ2_q * $signed({1'b0, gain_i_q});
      prod_d_q  <= deriv2_q * $signed({1'b0, gain_d_q});
      prod_ff_q <= target_q * $signed({1'b0, gain_ff_q});
      below3_q  <= below2_q;
      coast3_q  <= coast2_q;
    end
  end

  // sum, round half up, clamp; coast and bang-bang select their own drive
  logic signed [51:0] pid_sum;
  logic signed [39:0] pid_q;
  logic               clip_hi, clip_lo;
  logic signed [15:0] drive_d;
  logic               sat_d;

  always_comb begin
    pid_sum = 52'(prod_p_q) + 52'(prod_i_q) + 52'(prod_d_q) + 52'(prod_ff_q)
              + 52'sd2048;
    pid_q   = pid_sum[51:12];
    clip_hi = !pid_q[39] && (|pid_q[38:15]);
    clip_lo = pid_q[39] && !(&pid_q[38:15]);
    drive_d = '0;
    sat_d   = 1'b0;
    if (coast3_q) begin
      drive_d = '0;
    end else if (mode_q == MODE_BANG_BANG) begin
      drive_d = below3_q ? BangFull : 16'sd0;
    end else if (clip_hi) begin
      drive_d = DriveMax;
      sat_d   = 1'b1;
    end else if (clip_lo) begin
      drive_d = DriveMin;
      sat_d   = 1'b1;
    end else begin
      drive_d = pid_q[15:0];
    end
  end

  logic signed [15:0] drive_q;
  logic               coast_q, sat_q;

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      drive_q <= drive_d;
      coast_q <= coast3_q;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_level_o     = drive_q;
  assign coast_stop_o      = coast_q;
  assign drive_saturated_o = sat_q;

  `VPBB_ASSERT(a_coast_quiet, out_valid_q && coast_q |-> drive_q == '0 && !sat_q, "coast word not quiet")
  `VPBB_ASSERT(a_sat_at_limit, out_valid_q && sat_q |-> drive_q == DriveMax || drive_q == DriveMin, "saturation flag off limit")
  `VPBB_ASSERT(a_flip_clears, adv && v1_q && integ_on && sign_flip |=> integ_q == '0, "integral not cleared on sign change")
  `VPBB_ASSERT_NEVER(a_stall_moves, !adv && v1_q && $past(!adv) && !$stable(integ_q), "integral moved while stalled")

endmodule

`default_nettype wire
